// ----- hw/rtl/ssi_pkg.sv -----
// Shared widths, types and codes for the segment intersection splitter.
`timescale 1ns / 1ps
package ssi_pkg;

  // coordinate width and widths that follow from it
  localparam int CB    = 24;
  localparam int DW    = CB + 1;          // coordinate difference
  localparam int PW    = 2 * DW;          // signed product, det, tn, sn
  localparam int UW    = 2 * CB + 1;      // normalized det and tn magnitude
  localparam int QW    = CB;              // quotient bits (|q| <= |delta|)
  localparam int NW    = UW + QW;         // scaled numerator magnitude
  localparam int LW    = (UW + 1) / 2;    // low slice of tn for partial products
  localparam int HW    = UW - LW;         // high slice of tn
  localparam int IN_TW  = ((8 * CB + 7) / 8) * 8;
  localparam int OUT_TW = ((2 * CB + 2 + 7) / 8) * 8;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [DW-1:0] delta_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef enum logic [1:0] {
    OUT_NONE  = 2'd0,
    OUT_CROSS = 2'd1,
    OUT_SAME  = 2'd2
  } outcome_t;

  typedef struct packed {
    coord_t y3;
    coord_t x3;
    coord_t y2;
    coord_t x2;
    coord_t y1;
    coord_t x1;
    coord_t y0;
    coord_t x0;
  } seg_pair_t;

  // data that rides alongside the arithmetic
  typedef struct packed {
    seg_pair_t pts;
    outcome_t  kind;
    logic      neg_x;
    logic      neg_y;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [UW-1:0]   den;
    logic [UW-1:0]   tn;
    logic [CB-1:0]   adx;
    logic [CB-1:0]   ady;
  } front_out_t;

  typedef struct packed {
    side_t           side;
    logic [UW-1:0]   den;
    logic [NW-1:0]   num_x;
    logic [NW-1:0]   num_y;
  } scale_out_t;

  typedef struct packed {
    side_t           side;
    logic [UW-1:0]   den;
    logic [QW-1:0]   q_x;
    logic [QW-1:0]   q_y;
    logic [UW-1:0]   r_x;
    logic [UW-1:0]   r_y;
  } div_out_t;

endpackage

// ----- hw/rtl/segment_intersection_splitter.sv -----
// Top level: segment pair intersection with crossing point and split flags.
//
//  channel | direction | tdata                               | tuser
//  in_     | slave     | 8 coords, CB bits each              | -
//  out_    | master    | cross_x, cross_y, split flags       | outcome
//
// One request in per cycle while out_ is not stalled, one result per request; the path is
// 6 front stages, 2 scaling stages, 24 divider stages and 3 rounding/output stages.
// The divider has one stage per quotient bit, so latency tracks COORD width.
// rst_n (synchronous, active low) clears every valid bit; payload is not reset.
// A stall on out_ freezes the whole pipeline and drops in_tready in the same cycle.
`timescale 1ns / 1ps
module segment_intersection_splitter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // fields from bit 0 up: first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [ssi_pkg::IN_TW-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // fields from bit 0 up: cross_x, cross_y, split_first, split_second, zero fill
  output logic [ssi_pkg::OUT_TW-1:0]    out_tdata,
  // fields from bit 0 up: outcome
  output logic [1:0]                    out_tuser
);
  import ssi_pkg::*;

  typedef logic signed [CB:0]   qs_t;
  typedef logic signed [CB+1:0] sum_t;

  logic       en;
  seg_pair_t  in_pts;
  logic       fr_vld, sc_vld, dv_vld;
  front_out_t fr_data;
  scale_out_t sc_data;
  div_out_t   dv_data;

  // stage r1: signed floor quotient and remainder
  side_t         r1_side_r;
  logic [UW-1:0] r1_den_r;
  qs_t           r1_qx_r, r1_qy_r;
  logic [UW-1:0] r1_rx_r, r1_ry_r;
  logic          r1_vld_r;

  // stage r2: rounded coordinates
  side_t         r2_side_r;
  coord_t        r2_cx_r, r2_cy_r;
  logic          r2_vld_r;

  // output register
  logic [OUT_TW-1:0] out_data_r, out_data_nxt;
  outcome_t          out_kind_r;
  logic              out_vld_r;

  // floor of a signed quotient from magnitude division
  function automatic qs_t floor_q(logic neg, logic [QW-1:0] qm, logic [UW-1:0] r);
    qs_t m;
    m = qs_t'({1'b0, qm});
    if (neg) begin
      return -m - ((r != '0) ? qs_t'(1) : qs_t'(0));
    end
    return m;
  endfunction

  function automatic logic [UW-1:0] floor_r(logic neg, logic [UW-1:0] r,
                                           logic [UW-1:0] d);
    if (neg && (r != '0)) begin
      return d - r;
    end
    return r;
  endfunction

  // base + floor part, then half away from zero on the fraction r/d
  function automatic coord_t round_c(coord_t base, qs_t q, logic [UW-1:0] r,
                                     logic [UW-1:0] d);
    sum_t        f;
    logic [UW:0] tr;
    logic [UW:0] dd;
    logic        up;
    f  = sum_t'(base) + sum_t'(q);
    tr = {r, 1'b0};
    dd = {1'b0, d};
    up = (tr > dd) || ((tr == dd) && !f[CB+1]);
    return CB'(f + (up ? sum_t'(1) : sum_t'(0)));
  endfunction

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;
  assign in_pts    = seg_pair_t'(in_tdata[8*CB-1:0]);

  ssi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_pts    (in_pts),
    .out_valid (fr_vld),
    .out_data  (fr_data)
  );

  ssi_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_vld),
    .in_data   (fr_data),
    .out_valid (sc_vld),
    .out_data  (sc_data)
  );

  ssi_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sc_vld),
    .in_data   (sc_data),
    .out_valid (dv_vld),
    .out_data  (dv_data)
  );

  // output fields; zero unless a crossing was found
  always_comb begin
    logic sf, ss;
    sf = !(((r2_cx_r == r2_side_r.pts.x0) && (r2_cy_r == r2_side_r.pts.y0)) ||
           ((r2_cx_r == r2_side_r.pts.x1) && (r2_cy_r == r2_side_r.pts.y1)));
    ss = !(((r2_cx_r == r2_side_r.pts.x2) && (r2_cy_r == r2_side_r.pts.y2)) ||
           ((r2_cx_r == r2_side_r.pts.x3) && (r2_cy_r == r2_side_r.pts.y3)));
    out_data_nxt = '0;
    if (r2_side_r.kind == OUT_CROSS) begin
      out_data_nxt[2*CB+1:0] = {ss, sf, r2_cy_r, r2_cx_r};
    end
  end

  // rounding and output payload
  always_ff @(posedge clk) begin
    if (en) begin
      r1_side_r  <= dv_data.side;
      r1_den_r   <= dv_data.den;
      r1_qx_r    <= floor_q(dv_data.side.neg_x, dv_data.q_x, dv_data.r_x);
      r1_qy_r    <= floor_q(dv_data.side.neg_y, dv_data.q_y, dv_data.r_y);
      r1_rx_r    <= floor_r(dv_data.side.neg_x, dv_data.r_x, dv_data.den);
      r1_ry_r    <= floor_r(dv_data.side.neg_y, dv_data.r_y, dv_data.den);
      r2_side_r  <= r1_side_r;
      r2_cx_r    <= round_c(r1_side_r.pts.x0, r1_qx_r, r1_rx_r, r1_den_r);
      r2_cy_r    <= round_c(r1_side_r.pts.y0, r1_qy_r, r1_ry_r, r1_den_r);
      out_data_r <= out_data_nxt;
      out_kind_r <= r2_side_r.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r  <= 1'b0;
      r2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      r1_vld_r  <= dv_vld;
      r2_vld_r  <= r1_vld_r;
      out_vld_r <= r2_vld_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

// ----- hw/rtl/ssi_front.sv -----
// Front pipeline: box test, cross products, det sign normalize, parameter range test.
`timescale 1ns / 1ps
module ssi_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  ssi_pkg::seg_pair_t     in_pts,
  output logic                   out_valid,
  output ssi_pkg::front_out_t    out_data
);
  import ssi_pkg::*;

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  // stage a: captured points
  seg_pair_t a_pts_r;
  logic      a_vld_r;

  // stage b: differences and box test
  seg_pair_t b_pts_r;
  delta_t    b_dx1_r, b_dy1_r, b_dx2_r, b_dy2_r, b_ex_r, b_ey_r;
  logic      b_box_r, b_vld_r;
  delta_t    b_dx1_nxt, b_dy1_nxt, b_dx2_nxt, b_dy2_nxt, b_ex_nxt, b_ey_nxt;
  logic      b_box_nxt;

  // stage c: products
  seg_pair_t c_pts_r;
  delta_t    c_dx1_r, c_dy1_r;
  prod_t     c_p0_r, c_p1_r, c_p2_r, c_p3_r, c_p4_r, c_p5_r;
  logic      c_box_r, c_vld_r;

  // stage d: det, tn, sn
  seg_pair_t d_pts_r;
  delta_t    d_dx1_r, d_dy1_r;
  prod_t     d_det_r, d_tn_r, d_sn_r;
  logic      d_box_r, d_vld_r;

  // stage e: sign normalized
  seg_pair_t e_pts_r;
  delta_t    e_dx1_r, e_dy1_r;
  prod_t     e_det_r, e_tn_r, e_sn_r;
  logic      e_box_r, e_zero_r, e_vld_r;
  logic      e_neg;

  // stage f: classification
  front_out_t f_data_r;
  front_out_t f_data_nxt;
  logic       f_vld_r;
  logic       f_ok;

  always_comb begin
    b_dx1_nxt = DW'(a_pts_r.x1) - DW'(a_pts_r.x0);
    b_dy1_nxt = DW'(a_pts_r.y1) - DW'(a_pts_r.y0);
    b_dx2_nxt = DW'(a_pts_r.x3) - DW'(a_pts_r.x2);
    b_dy2_nxt = DW'(a_pts_r.y3) - DW'(a_pts_r.y2);
    b_ex_nxt  = DW'(a_pts_r.x0) - DW'(a_pts_r.x2);
    b_ey_nxt  = DW'(a_pts_r.y0) - DW'(a_pts_r.y2);
    // touching boxes count as overlap
    b_box_nxt =
      !(cmax(a_pts_r.x0, a_pts_r.x1) < cmin(a_pts_r.x2, a_pts_r.x3)) &&
      !(cmax(a_pts_r.x2, a_pts_r.x3) < cmin(a_pts_r.x0, a_pts_r.x1)) &&
      !(cmax(a_pts_r.y0, a_pts_r.y1) < cmin(a_pts_r.y2, a_pts_r.y3)) &&
      !(cmax(a_pts_r.y2, a_pts_r.y3) < cmin(a_pts_r.y0, a_pts_r.y1));
  end

  assign e_neg = d_det_r[PW-1];

  always_comb begin
    f_ok = !e_tn_r[PW-1] && (e_tn_r <= e_det_r) && !e_sn_r[PW-1] && (e_sn_r <= e_det_r);
    f_data_nxt.side.pts   = e_pts_r;
    f_data_nxt.side.neg_x = e_dx1_r[DW-1];
    f_data_nxt.side.neg_y = e_dy1_r[DW-1];
    if (!e_box_r) begin
      f_data_nxt.side.kind = OUT_NONE;
    end else if (e_zero_r) begin
      f_data_nxt.side.kind = OUT_SAME;
    end else if (f_ok) begin
      f_data_nxt.side.kind = OUT_CROSS;
    end else begin
      f_data_nxt.side.kind = OUT_NONE;
    end
    f_data_nxt.den = e_det_r[UW-1:0];
    f_data_nxt.tn  = e_tn_r[UW-1:0];
    f_data_nxt.adx = e_dx1_r[DW-1] ? CB'(-e_dx1_r) : CB'(e_dx1_r);
    f_data_nxt.ady = e_dy1_r[DW-1] ? CB'(-e_dy1_r) : CB'(e_dy1_r);
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      a_pts_r  <= in_pts;
      b_pts_r  <= a_pts_r;
      b_dx1_r  <= b_dx1_nxt;
      b_dy1_r  <= b_dy1_nxt;
      b_dx2_r  <= b_dx2_nxt;
      b_dy2_r  <= b_dy2_nxt;
      b_ex_r   <= b_ex_nxt;
      b_ey_r   <= b_ey_nxt;
      b_box_r  <= b_box_nxt;
      c_pts_r  <= b_pts_r;
      c_dx1_r  <= b_dx1_r;
      c_dy1_r  <= b_dy1_r;
      c_p0_r   <= PW'(b_dx1_r) * PW'(b_dy2_r);
      c_p1_r   <= PW'(b_dx2_r) * PW'(b_dy1_r);
      c_p2_r   <= PW'(b_dx2_r) * PW'(b_ey_r);
      c_p3_r   <= PW'(b_dy2_r) * PW'(b_ex_r);
      c_p4_r   <= PW'(b_dx1_r) * PW'(b_ey_r);
      c_p5_r   <= PW'(b_dy1_r) * PW'(b_ex_r);
      c_box_r  <= b_box_r;
      d_pts_r  <= c_pts_r;
      d_dx1_r  <= c_dx1_r;
      d_dy1_r  <= c_dy1_r;
      d_det_r  <= c_p0_r - c_p1_r;
      d_tn_r   <= c_p2_r - c_p3_r;
      d_sn_r   <= c_p4_r - c_p5_r;
      d_box_r  <= c_box_r;
      e_pts_r  <= d_pts_r;
      e_dx1_r  <= d_dx1_r;
      e_dy1_r  <= d_dy1_r;
      e_det_r  <= e_neg ? -d_det_r : d_det_r;
      e_tn_r   <= e_neg ? -d_tn_r : d_tn_r;
      e_sn_r   <= e_neg ? -d_sn_r : d_sn_r;
      e_zero_r <= (d_det_r == '0);
      e_box_r  <= d_box_r;
      f_data_r <= f_data_nxt;
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
    end
  end

  assign out_valid = f_vld_r;
  assign out_data  = f_data_r;

endmodule

// ----- hw/rtl/ssi_scale.sv -----
// Scaled numerators tn*|dx1| and tn*|dy1| from split partial products.
`timescale 1ns / 1ps
module ssi_scale (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  ssi_pkg::front_out_t    in_data,
  output logic                   out_valid,
  output ssi_pkg::scale_out_t    out_data
);
  import ssi_pkg::*;

  // stage g: partial products
  side_t              g_side_r;
  logic [UW-1:0]      g_den_r;
  logic [LW+CB-1:0]   g_xl_r, g_yl_r;
  logic [HW+CB-1:0]   g_xh_r, g_yh_r;
  logic               g_vld_r;

  // stage h: recombined
  scale_out_t         h_data_r;
  logic               h_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g_side_r <= in_data.side;
      g_den_r  <= in_data.den;
      g_xl_r   <= (LW+CB)'(in_data.tn[LW-1:0]) * (LW+CB)'(in_data.adx);
      g_yl_r   <= (LW+CB)'(in_data.tn[LW-1:0]) * (LW+CB)'(in_data.ady);
      g_xh_r   <= (HW+CB)'(in_data.tn[UW-1:LW]) * (HW+CB)'(in_data.adx);
      g_yh_r   <= (HW+CB)'(in_data.tn[UW-1:LW]) * (HW+CB)'(in_data.ady);
      h_data_r.side  <= g_side_r;
      h_data_r.den   <= g_den_r;
      h_data_r.num_x <= (NW'(g_xh_r) << LW) + NW'(g_xl_r);
      h_data_r.num_y <= (NW'(g_yh_r) << LW) + NW'(g_yl_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= in_valid;
      h_vld_r <= g_vld_r;
    end
  end

  assign out_valid = h_vld_r;
  assign out_data  = h_data_r;

endmodule

// ----- hw/rtl/ssi_divider.sv -----
// Pipelined restoring divider, two lanes (x and y) over one divisor, one quotient bit a stage.
`timescale 1ns / 1ps
module ssi_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  ssi_pkg::scale_out_t    in_data,
  output logic                   out_valid,
  output ssi_pkg::div_out_t      out_data
);
  import ssi_pkg::*;

  typedef struct packed {
    logic [UW-1:0] rem;
    logic [QW-1:0] lo;
    logic [QW-1:0] q;
  } lane_t;

  typedef struct packed {
    side_t         side;
    logic [UW-1:0] den;
    lane_t         lx;
    lane_t         ly;
  } stg_t;

  // one compare and subtract; remainder stays below the divisor
  function automatic lane_t div_step(lane_t l, logic [UW-1:0] d);
    lane_t          r;
    logic [UW:0]    t;
    logic [UW:0]    dd;
    t  = {l.rem, l.lo[QW-1]};
    dd = {1'b0, d};
    r.lo = {l.lo[QW-2:0], 1'b0};
    if (t >= dd) begin
      r.rem = UW'(t - dd);
      r.q   = {l.q[QW-2:0], 1'b1};
    end else begin
      r.rem = UW'(t);
      r.q   = {l.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  stg_t stg_r [QW];
  logic vld_r [QW];
  stg_t init;

  // quotient fits QW bits, so the top bits start as the partial remainder
  always_comb begin
    init.side   = in_data.side;
    init.den    = in_data.den;
    init.lx.rem = in_data.num_x[NW-1:QW];
    init.lx.lo  = in_data.num_x[QW-1:0];
    init.lx.q   = '0;
    init.ly.rem = in_data.num_y[NW-1:QW];
    init.ly.lo  = in_data.num_y[QW-1:0];
    init.ly.q   = '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    stg_t src;
    logic src_vld;
    if (k == 0) begin : g_first
      assign src     = init;
      assign src_vld = in_valid;
    end else begin : g_next
      assign src     = stg_r[k-1];
      assign src_vld = vld_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k].side <= src.side;
        stg_r[k].den  <= src.den;
        stg_r[k].lx   <= div_step(src.lx, src.den);
        stg_r[k].ly   <= div_step(src.ly, src.den);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end
  end

  assign out_valid     = vld_r[QW-1];
  assign out_data.side = stg_r[QW-1].side;
  assign out_data.den  = stg_r[QW-1].den;
  assign out_data.q_x  = stg_r[QW-1].lx.q;
  assign out_data.q_y  = stg_r[QW-1].ly.q;
  assign out_data.r_x  = stg_r[QW-1].lx.rem;
  assign out_data.r_y  = stg_r[QW-1].ly.rem;

endmodule

// ----- verif/segment_intersection_splitter_tb.sv -----
// Testbench for the segment intersection splitter: directed table plus random pairs.
`timescale 1ns / 1ps
module segment_intersection_splitter_tb;
  import ssi_pkg::*;

  localparam int IDLE_PCT   = 37;
  localparam int RAND_ITEMS = 1530;
  localparam int DOG_LIMIT  = 20000;
  localparam int DRAIN      = 60;

  typedef struct packed {
    logic        split_second;
    logic        split_first;
    coord_t      cross_y;
    coord_t      cross_x;
    outcome_t    kind;
  } crossing_t;

  // directed row: pair, whether the expectation is typed in, and the typed one
  typedef struct {
    seg_pair_t pair;
    bit        typed;
    crossing_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;
  logic [1:0] out_tuser;

  crossing_t pending_q[$];
  int fails = 0;
  int dog = 0;
  bit calm = 1'b0;

  segment_intersection_splitter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // round(n/d) half away from zero, d > 0
  function automatic longint round_div(logic signed [127:0] n, logic signed [127:0] d);
    logic signed [127:0] m;
    logic signed [127:0] q;
    m = (n < 0) ? -n : n;
    q = (2 * m + d) / (2 * d);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  // expected crossing for one segment pair
  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t r;
    longint x0, y0, x1, y1, x2, y2, x3, y3, dx1, dy1, dx2, dy2, ex, ey, cx, cy;
    logic signed [127:0] det, tn, sn;
    r = '0;
    r.kind = OUT_NONE;
    x0 = p.x0; y0 = p.y0; x1 = p.x1; y1 = p.y1;
    x2 = p.x2; y2 = p.y2; x3 = p.x3; y3 = p.y3;
    dx1 = x1 - x0; dy1 = y1 - y0; dx2 = x3 - x2; dy2 = y3 - y2;
    ex = x0 - x2; ey = y0 - y2;
    // bounding boxes, touching counts as overlap
    if ((x0 > x1 ? x0 : x1) < (x2 < x3 ? x2 : x3)) return r;
    if ((x2 > x3 ? x2 : x3) < (x0 < x1 ? x0 : x1)) return r;
    if ((y0 > y1 ? y0 : y1) < (y2 < y3 ? y2 : y3)) return r;
    if ((y2 > y3 ? y2 : y3) < (y0 < y1 ? y0 : y1)) return r;
    det = 128'(dx1) * 128'(dy2) - 128'(dx2) * 128'(dy1);
    if (det == 0) begin
      r.kind = OUT_SAME;
      return r;
    end
    tn = 128'(dx2) * 128'(ey) - 128'(dy2) * 128'(ex);
    sn = 128'(dx1) * 128'(ey) - 128'(dy1) * 128'(ex);
    if (det < 0) begin
      det = -det; tn = -tn; sn = -sn;
    end
    if (tn < 0 || tn > det || sn < 0 || sn > det) return r;
    cx = round_div(128'(x0) * det + tn * 128'(dx1), det);
    cy = round_div(128'(y0) * det + tn * 128'(dy1), det);
    r.kind = OUT_CROSS;
    r.cross_x = coord_t'(cx);
    r.cross_y = coord_t'(cy);
    r.split_first = !((cx == x0 && cy == y0) || (cx == x1 && cy == y1));
    r.split_second = !((cx == x2 && cy == y2) || (cx == x3 && cy == y3));
    return r;
  endfunction

  function automatic seg_pair_t mk_pair(int a, int b, int c, int d, int e, int f,
                                        int g, int h);
    seg_pair_t p;
    p.x0 = coord_t'(a); p.y0 = coord_t'(b); p.x1 = coord_t'(c); p.y1 = coord_t'(d);
    p.x2 = coord_t'(e); p.y2 = coord_t'(f); p.x3 = coord_t'(g); p.y3 = coord_t'(h);
    return p;
  endfunction

  function automatic crossing_t mk_res(outcome_t k, int cx, int cy, bit sf, bit ss);
    crossing_t r;
    r.kind = k; r.cross_x = coord_t'(cx); r.cross_y = coord_t'(cy);
    r.split_first = sf; r.split_second = ss;
    return r;
  endfunction

  function automatic coord_t rnd_coord(int span);
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom());
      1: v = $urandom_range(0, 2 * span) - span;
      2: v = $urandom_range(0, 1) ? 32'sh7fffff - $urandom_range(0, span)
                                   : -32'sh800000 + $urandom_range(0, span);
      default: v = $urandom_range(0, 40) - 20;
    endcase
    return coord_t'(v);
  endfunction

  // random pair, mostly built to cross or overlap so the deep path is reached
  function automatic seg_pair_t rnd_pair();
    seg_pair_t p;
    int span;
    span = $urandom_range(0, 1) ? 1000 : 8000000;
    p = {rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span),
         rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span)};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // second segment derived from the points of the first: a crossing is likely
        p.x2 = p.x0 - (p.x1 >>> 2); p.y2 = p.y1 - (p.y0 >>> 2);
        p.x3 = (p.x0 >>> 1) + (p.x1 >>> 1) + ((p.x0 >>> 1) - (p.x2 >>> 1));
        p.y3 = (p.y0 >>> 1) + (p.y1 >>> 1) + ((p.y0 >>> 1) - (p.y2 >>> 1));
      end
      4: begin
        // shares an end point
        p.x2 = p.x1; p.y2 = p.y1;
      end
      5: begin
        // starts at the first start point: a copy, a degenerate point or a mixed end
        p.x2 = p.x0; p.y2 = p.y0;
        p.x3 = $urandom_range(0, 1) ? p.x1 : p.x0;
        p.y3 = $urandom_range(0, 1) ? p.y1 : p.y0;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pair(seg_pair_t p);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TW'(p);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q = {pending_q, predict_crossing(p)};
  endtask

  task automatic send_typed(dir_row_t row);
    crossing_t got;
    send_pair(row.pair);
    got = pending_q[pending_q.size() - 1];
    if (row.typed && got != row.want) begin
      $error("typed row disagrees with prediction: exp %h act %h", row.want, got);
      fails++;
    end
    if (row.typed) pending_q[pending_q.size() - 1] = row.want;
  endtask

  // result side: random stalls and field checks
  always @(posedge clk) begin
    crossing_t e;
    if (rst_n) begin
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) dog <= 0;
      else dog <= dog + 1;
      if (out_tvalid && out_tready) begin
        if (pending_q.size() == 0) begin
          $error("result with no request waiting");
          fails++;
        end else begin
          e = pending_q.pop_front();
          if (out_tuser != e.kind) begin
            $error("outcome exp %0d act %0d", e.kind, out_tuser); fails++;
          end
          if (out_tdata[CB-1:0] != e.cross_x) begin
            $error("cross_x exp %0d act %0d", e.cross_x, $signed(out_tdata[CB-1:0]));
            fails++;
          end
          if (out_tdata[2*CB-1:CB] != e.cross_y) begin
            $error("cross_y exp %0d act %0d", e.cross_y, $signed(out_tdata[2*CB-1:CB]));
            fails++;
          end
          if (out_tdata[2*CB] != e.split_first) begin
            $error("split_first exp %0b act %0b", e.split_first, out_tdata[2*CB]);
            fails++;
          end
          if (out_tdata[2*CB+1] != e.split_second) begin
            $error("split_second exp %0b act %0b", e.split_second, out_tdata[2*CB+1]);
            fails++;
          end
        end
      end
      if (dog >= DOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  dir_row_t dir_rows[$];

  initial begin
    int n;
    dir_row_t row;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, each outcome, touching, shared end points, degenerate
    row.typed = 1'b1;
    row.pair = mk_pair(0, 0, 10, 10, 0, 10, 10, 0);
    row.want = mk_res(OUT_CROSS, 5, 5, 1, 1); dir_rows = {dir_rows, row};
    row.pair = mk_pair(0, 0, 1, 1, 5, 5, 6, 6);
    row.want = mk_res(OUT_NONE, 0, 0, 0, 0); dir_rows = {dir_rows, row};
    row.pair = mk_pair(0, 0, 4, 4, 1, 1, 3, 3);
    row.want = mk_res(OUT_SAME, 0, 0, 0, 0); dir_rows = {dir_rows, row};
    row.pair = mk_pair(3, 3, 3, 3, 3, 3, 3, 3);
    row.want = mk_res(OUT_SAME, 0, 0, 0, 0); dir_rows = {dir_rows, row};
    row.pair = mk_pair(0, 0, 4, 0, 4, 0, 4, 4);
    row.want = mk_res(OUT_CROSS, 4, 0, 0, 0); dir_rows = {dir_rows, row};
    row.pair = mk_pair(0, 0, 4, 0, 2, 0, 2, 4);
    row.want = mk_res(OUT_CROSS, 2, 0, 1, 0); dir_rows = {dir_rows, row};
    row.pair = mk_pair(0, 0, 4, 4, 0, 3, 1, 3);
    row.want = mk_res(OUT_NONE, 0, 0, 0, 0); dir_rows = {dir_rows, row};
    // full-range diagonals meet at -0.5, which rounds away from zero
    row.pair = mk_pair(-8388608, -8388608, 8388607, 8388607,
                       -8388608, 8388607, 8388607, -8388608);
    row.want = mk_res(OUT_CROSS, -1, -1, 1, 1); dir_rows = {dir_rows, row};
    row.pair = mk_pair(-8388608, -8388608, -8388608, -8388608,
                       8388607, 8388607, 8388607, 8388607);
    row.want = mk_res(OUT_NONE, 0, 0, 0, 0); dir_rows = {dir_rows, row};
    row.typed = 1'b0;
    row.pair = mk_pair(0, 0, 3, 1, 0, 1, 3, 0); dir_rows = {dir_rows, row};
    row.pair = mk_pair(0, 0, -3, -1, 0, -1, -3, 0); dir_rows = {dir_rows, row};
    row.pair = mk_pair(-8388608, 8388607, 8388607, -8388607,
                       -8388608, -8388608, 8388607, 8388606); dir_rows = {dir_rows, row};
    row.pair = mk_pair(-1, -1, 1, 2, 1, -1, -2, 1); dir_rows = {dir_rows, row};
    row.pair = mk_pair(8388607, 0, -8388608, 1, 0, -8388608, 1, 8388607);
    dir_rows = {dir_rows, row};
    row.pair = mk_pair(0, 0, 7, 3, 2, -5, 3, 9); dir_rows = {dir_rows, row};
    row.pair = mk_pair(-1, -1, -1, -1, -1, -1, -1, -1); dir_rows = {dir_rows, row};
    row.pair = mk_pair(-5592405, 5592405, 5592405, -5592406, 1, -1, -1, 1);
    dir_rows = {dir_rows, row};
    foreach (dir_rows[i]) send_typed(dir_rows[i]);

    // drain once with the sender held back
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);

    // random, with a stretch of full throughput
    n = 0;
    while (n < RAND_ITEMS) begin
      calm = (n >= 600 && n < 800);
      send_pair(rnd_pair());
      n++;
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
